[rtl/core/hdsu_pkg.sv]
package hdsu_pkg;

    // Receive queue depth and the widths that follow from it
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Fixed field widths
    localparam int DATA_W     = 9;
    localparam int PERIOD_W   = 16;
    localparam int TX_W       = 12;
    localparam int RX_W       = 11;
    localparam int BITCNT_W   = 4;
    localparam int EVENT_W    = 2;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd372;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NINE_BIT   = 2'd1;

    // Receive event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_QUEUED  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_FRAMING = 2'd2;
    localparam logic [EVENT_W-1:0] EV_FULL    = 2'd3;

    // Status from the receive queue to the datapath
    typedef struct packed {
        logic                  pop_ok;
        logic                  full;
        logic [FIFO_CNT_W-1:0] fill;
        logic [FIFO_CNT_W-1:0] fill_next;
    } t_fifo_stat;

endpackage

[rtl/core/half_duplex_single_wire_uart.sv]
// Single-pin half-duplex UART. Each input item is one timer clock: the pin
// level, the transmit/receive direction, an optional send request and an
// optional pop of the receive queue; each item yields exactly one result
// item with the pin drive, send and pop status and the receive event. One
// item is accepted per clock while the output side does not stall; an item
// passes an input register and then the result register, and waits in the
// input register while the output side stalls. The bit period is a register;
// a write to it restarts the bit timer and abandons a frame being sent.
// Frames are 8N2 or 9N2, LSB first, sampled at mid bit; good frames go to
// a small receive queue, bad or overflowing frames are dropped and flagged.
module half_duplex_single_wire_uart
    import hdsu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_line_in,
    input  logic                  i_transmit_mode,
    input  logic                  i_send_valid,
    input  logic [DATA_W-1:0]     i_send_data,
    input  logic                  i_pop_req,
    // result item channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_line_out,
    output logic                  o_line_drive,
    output logic                  o_send_accepted,
    output logic                  o_tx_busy,
    output logic                  o_pop_valid,
    output logic [DATA_W-1:0]     o_pop_data,
    output logic [EVENT_W-1:0]    o_rx_event,
    output logic [COUNT_W-1:0]    o_fifo_count
);

    // Configuration
    logic [PERIOD_W-1:0] r_bit_period;
    logic                r_nine_bit;

    // Input register
    logic                r_in_vld;
    logic                r_in_line;
    logic                r_in_txm;
    logic                r_in_sv;
    logic [DATA_W-1:0]   r_in_sdata;
    logic                r_in_pop;

    // UART state
    logic [PERIOD_W-1:0] r_tick;
    logic [TX_W-1:0]     r_tx_shift;
    logic                r_line_latch;
    logic                r_prev_line;
    logic                r_rx_sampling;
    logic [PERIOD_W-1:0] r_sample_point;
    logic [RX_W-1:0]     r_rx_shift;
    logic [BITCNT_W-1:0] r_rx_cnt;

    // Result register
    logic                r_out_vld;
    logic                r_out_line_out;
    logic                r_out_line_drive;
    logic                r_out_accepted;
    logic                r_out_busy;
    logic                r_out_pop_valid;
    logic [DATA_W-1:0]   r_out_pop_data;
    logic [EVENT_W-1:0]  r_out_event;
    logic [COUNT_W-1:0]  r_out_count;

    // Next values
    logic [PERIOD_W-1:0] n_tick;
    logic [TX_W-1:0]     n_tx_shift;
    logic                n_line_latch;
    logic                n_rx_sampling;
    logic [PERIOD_W-1:0] n_sample_point;
    logic [RX_W-1:0]     n_rx_shift;
    logic [BITCNT_W-1:0] n_rx_cnt;
    logic [EVENT_W-1:0]  n_event;
    logic                n_accepted;

    // Step datapath
    logic                advance;
    logic                cfg_wr;
    logic                cfg_period_wr;
    logic [PERIOD_W-1:0] eff_period;
    logic [PERIOD_W:0]   period_x;
    logic                wrap;
    logic [PERIOD_W:0]   half_sum;
    logic [PERIOD_W:0]   half_mod;
    logic [TX_W-1:0]     tx_mid;
    logic [TX_W-1:0]     tx_frame;
    logic                sample_hit;
    logic [RX_W-1:0]     rx_data;
    logic [BITCNT_W:0]   rx_bits;
    logic                rx_last;
    logic                frame_ok;
    logic                rx_push;
    logic                edge_hit;
    logic [DATA_W-1:0]   data_mask;
    logic [DATA_W-1:0]   fifo_rd_data;
    t_fifo_stat          fifo_stat;

    // Handshakes
    assign advance       = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall    = r_in_vld & ~advance;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid & o_cfg_ready;
    assign cfg_period_wr = cfg_wr & (i_cfg_index == REG_BIT_PERIOD);

    // Bit timer and mid-bit sample point
    always_comb begin
        eff_period = (r_bit_period == '0) ? PERIOD_W'(1) : r_bit_period;
        period_x   = {1'b0, eff_period};
        wrap       = (({1'b0, r_tick} + 1'b1) >= period_x);
        n_tick     = wrap ? '0 : r_tick + 1'b1;
        half_sum   = {1'b0, r_tick} + {2'b00, eff_period[PERIOD_W-1:1]};
        half_mod   = (half_sum >= period_x) ? half_sum - period_x : half_sum;
        if (half_mod >= period_x) begin
            half_mod = '0;
        end
        data_mask  = r_nine_bit ? {DATA_W{1'b1}} : {1'b0, {(DATA_W-1){1'b1}}};
    end

    // Transmit shifter and send accept
    always_comb begin
        tx_mid       = r_tx_shift;
        n_line_latch = r_line_latch;
        if (wrap && (r_tx_shift != '0)) begin
            n_line_latch = r_tx_shift[0];
            tx_mid       = {1'b0, r_tx_shift[TX_W-1:1]};
        end
        if (r_nine_bit) begin
            tx_frame = {2'b11, r_in_sdata, 1'b0};
        end else begin
            tx_frame = {3'b011, r_in_sdata[DATA_W-2:0], 1'b0};
        end
        n_accepted = r_in_sv & (tx_mid == '0);
        n_tx_shift = n_accepted ? tx_frame : tx_mid;
    end

    // Receive sampler and edge capture
    always_comb begin
        sample_hit = r_rx_sampling & (r_tick == r_sample_point);
        rx_data    = {1'b0, r_rx_shift[RX_W-1:1]};
        if (r_nine_bit) begin
            rx_data[10] = rx_data[10] | r_in_line;
        end else begin
            rx_data[9] = rx_data[9] | r_in_line;
        end
        rx_bits  = {1'b0, r_rx_cnt} + 1'b1;
        rx_last  = rx_bits >= (r_nine_bit ? (BITCNT_W+1)'(11) : (BITCNT_W+1)'(10));
        frame_ok = ~rx_data[0] & (r_nine_bit ? rx_data[10] : rx_data[9]);
        rx_push  = sample_hit & rx_last & frame_ok;

        n_rx_sampling  = r_rx_sampling;
        n_sample_point = r_sample_point;
        n_rx_shift     = r_rx_shift;
        n_rx_cnt       = r_rx_cnt;
        n_event        = EV_NONE;
        if (sample_hit) begin
            if (rx_last) begin
                n_rx_sampling = 1'b0;
                if (!frame_ok) begin
                    n_event = EV_FRAMING;
                end else if (fifo_stat.full) begin
                    n_event = EV_FULL;
                end else begin
                    n_event = EV_QUEUED;
                end
            end else begin
                n_rx_cnt   = rx_bits[BITCNT_W-1:0];
                n_rx_shift = rx_data;
            end
        end

        edge_hit = ~r_in_txm & ~r_rx_sampling & r_prev_line & ~r_in_line;
        if (edge_hit) begin
            n_sample_point = half_mod[PERIOD_W-1:0];
            n_rx_shift     = '0;
            n_rx_cnt       = '0;
            n_rx_sampling  = 1'b1;
        end
    end

    // Receive queue
    hdsu_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_pop_req   (r_in_pop),
        .i_push      (rx_push),
        .i_push_data (rx_data[DATA_W:1]),
        .o_rd_data   (fifo_rd_data),
        .o_stat      (fifo_stat)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_line  <= i_line_in;
            r_in_txm   <= i_transmit_mode;
            r_in_sv    <= i_send_valid;
            r_in_sdata <= i_send_data;
            r_in_pop   <= i_pop_req;
        end
    end

    // UART state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period   <= BIT_PERIOD_RESET;
            r_nine_bit     <= 1'b0;
            r_tick         <= '0;
            r_tx_shift     <= '0;
            r_line_latch   <= 1'b1;
            r_prev_line    <= 1'b1;
            r_rx_sampling  <= 1'b0;
            r_sample_point <= '0;
            r_rx_shift     <= '0;
            r_rx_cnt       <= '0;
        end else begin
            // a period write restarts the timer and drops the frame in flight
            if (cfg_period_wr) begin
                r_tick     <= '0;
                r_tx_shift <= '0;
            end else if (advance) begin
                r_tick     <= n_tick;
                r_tx_shift <= n_tx_shift;
            end
            if (advance) begin
                r_line_latch   <= n_line_latch;
                r_prev_line    <= r_in_line;
                r_rx_sampling  <= n_rx_sampling;
                r_sample_point <= n_sample_point;
                r_rx_shift     <= n_rx_shift;
                r_rx_cnt       <= n_rx_cnt;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_BIT_PERIOD: r_bit_period <= i_cfg_data;
                    REG_NINE_BIT:   r_nine_bit   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (advance) begin
            r_out_line_out   <= r_in_txm ? n_line_latch : 1'b1;
            r_out_line_drive <= r_in_txm;
            r_out_accepted   <= n_accepted;
            r_out_busy       <= (n_tx_shift != '0);
            r_out_pop_valid  <= fifo_stat.pop_ok;
            r_out_pop_data   <= fifo_stat.pop_ok ? (fifo_rd_data & data_mask) : '0;
            r_out_event      <= n_event;
            r_out_count      <= COUNT_W'(fifo_stat.fill_next);
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_line_out      = r_out_line_out;
    assign o_line_drive    = r_out_line_drive;
    assign o_send_accepted = r_out_accepted;
    assign o_tx_busy       = r_out_busy;
    assign o_pop_valid     = r_out_pop_valid;
    assign o_pop_data      = r_out_pop_data;
    assign o_rx_event      = r_out_event;
    assign o_fifo_count    = r_out_count;

    // Bit timer stays inside the period
    a_tick_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < eff_period)
        else $error("bit timer beyond period");

    // Bit counter never passes the longest frame
    a_rx_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_cnt <= BITCNT_W'(10))
        else $error("receive bit count out of range");

    // Queue fill never exceeds its depth
    a_fifo_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.fill <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("receive queue overfilled");

    // A taken send always leaves the transmitter busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_accepted |=> r_out_busy)
        else $error("send taken but transmitter idle");

endmodule

[rtl/core/hdsu_fifo.sv]
module hdsu_fifo
    import hdsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_pop_req,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic [DATA_W-1:0] o_rd_data,
    output t_fifo_stat        o_stat
);

    logic [DATA_W-1:0]     r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_CNT_W-1:0] r_fill;

    logic                  pop_ok;
    logic                  push_ok;
    logic                  full;
    logic [FIFO_CNT_W-1:0] fill_mid;
    logic [FIFO_CNT_W-1:0] n_fill;
    logic [FIFO_PTR_W-1:0] n_rd;
    logic [FIFO_PTR_W-1:0] n_wr;

    // Pop sees the queue as it was; push sees the space the pop freed
    always_comb begin
        pop_ok   = i_en & i_pop_req & (r_fill != '0);
        fill_mid = r_fill - FIFO_CNT_W'(pop_ok);
        full     = (fill_mid == FIFO_CNT_W'(FIFO_DEPTH));
        push_ok  = i_en & i_push & ~full;
        n_fill   = fill_mid + FIFO_CNT_W'(push_ok);
        n_rd     = r_rd;
        n_wr     = r_wr;
        if (pop_ok) begin
            n_rd = (r_rd == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push_ok) begin
            n_wr = (r_wr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
    end

    assign o_rd_data        = r_mem[r_rd];
    assign o_stat.pop_ok    = pop_ok;
    assign o_stat.full      = full;
    assign o_stat.fill      = r_fill;
    assign o_stat.fill_next = n_fill;

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_wr   <= '0;
            r_fill <= '0;
        end else begin
            r_rd   <= n_rd;
            r_wr   <= n_wr;
            r_fill <= n_fill;
        end
    end

endmodule
